// ===== sv/fixed_block_allocator_core_macros.svh =====
// ----------------------------------------------------------------------------
// fixed_block_allocator_core_macros.svh
// Assertion helpers used by the checker of the block allocator.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define FIXED_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define FBA_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define FBA_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== sv/fba_pkg.sv =====
// ----------------------------------------------------------------------------
// fba_pkg
// Types and constants of the fixed block allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fba_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int IDX_W      = 8;
    localparam int CNT_W      = 9;
    localparam int STRIDE_W   = 13;
    localparam int ADDR_W     = 64;
    localparam int TOTAL_W    = 32;
    localparam int PROD_W     = IDX_W + STRIDE_W;

    localparam int MAX_LIM_INT = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;
    localparam logic [CNT_W-1:0] MAX_LIM = CNT_W'(MAX_LIM_INT);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_SAT = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_ONE = TOTAL_W'(1);

    // APB register map, 8-byte spacing
    localparam int APB_AW = 5;
    localparam logic [APB_AW-1:0] REG_POOL_BASE    = APB_AW'(0);
    localparam logic [APB_AW-1:0] REG_BLOCK_STRIDE = APB_AW'(8);
    localparam logic [APB_AW-1:0] REG_BLOCK_LIMIT  = APB_AW'(16);

    localparam logic [ADDR_W-1:0]   RST_POOL_BASE    = '0;
    localparam logic [STRIDE_W-1:0] RST_BLOCK_STRIDE = STRIDE_W'(16);
    localparam logic [CNT_W-1:0]    RST_BLOCK_LIMIT  = CNT_W'(256);

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [IDX_W-1:0] free_index;
    } req_t;

    typedef struct packed {
        logic               granted;
        logic [IDX_W-1:0]   block_index;
        logic [ADDR_W-1:0]  block_address;
        logic [CNT_W-1:0]   in_use_count;
        logic [CNT_W-1:0]   peak_in_use;
        logic [TOTAL_W-1:0] alloc_total;
        logic [TOTAL_W-1:0] free_total;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   pool_base;
        logic [STRIDE_W-1:0] block_stride;
        logic [CNT_W-1:0]    block_limit;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

endpackage

`default_nettype wire

// ===== sv/fba_regs.sv =====
// ----------------------------------------------------------------------------
// fba_regs
// APB configuration registers: pool base, block stride, block limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fba_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [fba_pkg::APB_AW-1:0] paddr,
    input  wire logic [63:0]                pwdata,
    output logic      [63:0]                prdata,
    output logic                            pready,
    output fba_pkg::cfg_t                   cfg
);

    fba_pkg::cfg_t cfg_reg;
    fba_pkg::cfg_t cfg_next;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr)
                fba_pkg::REG_POOL_BASE:
                    cfg_next.pool_base = pwdata;
                fba_pkg::REG_BLOCK_STRIDE:
                    cfg_next.block_stride = pwdata[fba_pkg::STRIDE_W-1:0];
                fba_pkg::REG_BLOCK_LIMIT:
                    cfg_next.block_limit = pwdata[fba_pkg::CNT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pool_base    <= fba_pkg::RST_POOL_BASE;
            cfg_reg.block_stride <= fba_pkg::RST_BLOCK_STRIDE;
            cfg_reg.block_limit  <= fba_pkg::RST_BLOCK_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (paddr)
            fba_pkg::REG_POOL_BASE:
                prdata = cfg_reg.pool_base;
            fba_pkg::REG_BLOCK_STRIDE:
                prdata = {{(64-fba_pkg::STRIDE_W){1'b0}}, cfg_reg.block_stride};
            fba_pkg::REG_BLOCK_LIMIT:
                prdata = {{(64-fba_pkg::CNT_W){1'b0}}, cfg_reg.block_limit};
            default:
                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== sv/fba_ctrl.sv =====
// ----------------------------------------------------------------------------
// fba_ctrl
// Request sequencer: capture, commit, and response valid handling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fba_ctrl (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    req_valid,
    output logic         req_ready,
    output logic         rsp_valid,
    input  wire logic    rsp_ready,
    output fba_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   out_free;

    assign req_ready   = (state_reg == ST_IDLE);
    assign out_free    = !rsp_valid_reg || rsp_ready;
    assign cmd.capture = req_valid && req_ready;
    assign cmd.commit  = (state_reg == ST_EXEC) && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (cmd.commit)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

// ===== sv/fba_datapath.sv =====
// ----------------------------------------------------------------------------
// fba_datapath
// Free list, bump index, counters, address arithmetic and response word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fba_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire fba_pkg::cmd_t cmd,
    input  wire fba_pkg::cfg_t cfg,
    input  wire fba_pkg::req_t req_data,
    output fba_pkg::rsp_t      rsp_data
);

    localparam int IW = fba_pkg::IDX_W;
    localparam int CW = fba_pkg::CNT_W;
    localparam int TW = fba_pkg::TOTAL_W;
    localparam int PW = fba_pkg::PROD_W;
    localparam int AW = fba_pkg::ADDR_W;

    logic [IW-1:0] link_mem [fba_pkg::MAX_BLOCKS];
    logic [fba_pkg::MAX_BLOCKS-1:0] link_valid_reg;

    logic [IW-1:0] head_reg;
    logic          nonempty_reg;
    logic [CW-1:0] fresh_reg;
    logic [CW-1:0] in_use_reg;
    logic [CW-1:0] peak_reg;
    logic [TW-1:0] alloc_cnt_reg;
    logic [TW-1:0] free_cnt_reg;

    // captured at accept
    logic          is_free_reg;
    logic [IW-1:0] fidx_reg;
    logic          free_ok_reg;
    logic          pop_reg;
    logic          bump_reg;
    logic [IW-1:0] idx_reg;
    logic [PW-1:0] prod_reg;
    logic [IW-1:0] link_rd_reg;
    logic          valid_rd_reg;

    logic [CW-1:0] eff_limit;
    logic          pop_ok;
    logic          bump_ok;
    logic [IW-1:0] idx_sel;

    logic          alloc_ok;
    logic [IW-1:0] head_next;
    logic          nonempty_next;
    logic [CW-1:0] fresh_next;
    logic [CW-1:0] in_use_next;
    logic [CW-1:0] peak_next;
    logic [TW-1:0] alloc_cnt_next;
    logic [TW-1:0] free_cnt_next;
    logic          link_we;

    fba_pkg::rsp_t rsp_reg;
    fba_pkg::rsp_t rsp_next;

    always_comb
    begin
        eff_limit = cfg.block_limit;
        if (eff_limit > fba_pkg::MAX_LIM)
            eff_limit = fba_pkg::MAX_LIM;
    end

    assign pop_ok  = nonempty_reg && (int'(head_reg) < fba_pkg::MAX_BLOCKS);
    assign bump_ok = fresh_reg < eff_limit;
    assign idx_sel = pop_ok ? head_reg : fresh_reg[IW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            is_free_reg  <= (req_data.req_type == fba_pkg::REQ_FREE);
            fidx_reg     <= req_data.free_index;
            free_ok_reg  <= int'(req_data.free_index) < fba_pkg::MAX_BLOCKS;
            pop_reg      <= pop_ok;
            bump_reg     <= bump_ok && !pop_ok;
            idx_reg      <= idx_sel;
            prod_reg     <= PW'(idx_sel) * PW'(cfg.block_stride);
            valid_rd_reg <= link_valid_reg[head_reg];
        end
    end

    // link store: read at the head on accept, written on a committed free
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            link_rd_reg <= link_mem[head_reg];
        if (link_we)
            link_mem[fidx_reg] <= head_reg;
    end

    assign alloc_ok = !is_free_reg && (pop_reg || bump_reg);
    assign link_we  = cmd.commit && is_free_reg && free_ok_reg;

    always_comb
    begin
        head_next      = head_reg;
        nonempty_next  = nonempty_reg;
        fresh_next     = fresh_reg;
        in_use_next    = in_use_reg;
        alloc_cnt_next = alloc_cnt_reg;
        free_cnt_next  = free_cnt_reg;
        if (alloc_ok)
        begin
            if (pop_reg)
            begin
                head_next     = link_rd_reg;
                nonempty_next = valid_rd_reg;
            end
            else
            begin
                fresh_next = fresh_reg + fba_pkg::CNT_ONE;
            end
            alloc_cnt_next = alloc_cnt_reg + fba_pkg::TOTAL_ONE;
            if (in_use_reg != fba_pkg::CNT_SAT)
                in_use_next = in_use_reg + fba_pkg::CNT_ONE;
        end
        else if (is_free_reg && free_ok_reg)
        begin
            head_next     = fidx_reg;
            nonempty_next = 1'b1;
            free_cnt_next = free_cnt_reg + fba_pkg::TOTAL_ONE;
            if (in_use_reg != '0)
                in_use_next = in_use_reg - fba_pkg::CNT_ONE;
        end
        peak_next = (in_use_next > peak_reg) ? in_use_next : peak_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            nonempty_reg   <= 1'b0;
            fresh_reg      <= '0;
            in_use_reg     <= '0;
            peak_reg       <= '0;
            alloc_cnt_reg  <= '0;
            free_cnt_reg   <= '0;
            link_valid_reg <= '0;
        end
        else if (cmd.commit)
        begin
            head_reg      <= head_next;
            nonempty_reg  <= nonempty_next;
            fresh_reg     <= fresh_next;
            in_use_reg    <= in_use_next;
            peak_reg      <= peak_next;
            alloc_cnt_reg <= alloc_cnt_next;
            free_cnt_reg  <= free_cnt_next;
            if (link_we)
                link_valid_reg[fidx_reg] <= nonempty_reg;
        end
    end

    always_comb
    begin
        rsp_next.granted       = alloc_ok || (is_free_reg && free_ok_reg);
        rsp_next.block_index   = alloc_ok ? idx_reg : '0;
        rsp_next.block_address = alloc_ok ? (cfg.pool_base + AW'(prod_reg)) : '0;
        rsp_next.in_use_count  = in_use_next;
        rsp_next.peak_in_use   = peak_next;
        rsp_next.alloc_total   = alloc_cnt_next;
        rsp_next.free_total    = free_cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            rsp_reg <= rsp_next;
    end

    assign rsp_data = rsp_reg;

endmodule

`default_nettype wire

// ===== sv/fixed_block_allocator_core.sv =====
// A result word is registered when its request commits; a commit waits while the
// output register holds a result that is not yet taken. Only one request is in
// flight: the list head's link is read on accept and the head updated on commit.
// A finished result waits in the output register; the next request is taken meanwhile.
// Reset (async, rst_n low) clears list state, link valid bits, counters, control state
// and config registers at once; link store contents are not cleared and need no pass.
// ----------------------------------------------------------------------------
// fixed_block_allocator_core
// Fixed-size block allocator with a LIFO free list and a bump index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fixed_block_allocator_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    output logic                            req_ready,
    input  wire fba_pkg::req_t              req_data,
    output logic                            rsp_valid,
    input  wire logic                       rsp_ready,
    output fba_pkg::rsp_t                   rsp_data,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [fba_pkg::APB_AW-1:0] paddr,
    input  wire logic [63:0]                pwdata,
    output logic      [63:0]                prdata,
    output logic                            pready
);

    fba_pkg::cfg_t cfg;
    fba_pkg::cmd_t cmd;

    fba_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    fba_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg),
        .req_data (req_data),
        .rsp_data (rsp_data)
    );

endmodule

`default_nettype wire

// ===== sv/fba_checker.sv =====
// ----------------------------------------------------------------------------
// fba_checker
// Port-level checks of the block allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "fixed_block_allocator_core_macros.svh"

module fba_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    input  wire logic          req_ready,
    input  wire logic          rsp_valid,
    input  wire logic          rsp_ready,
    input  wire fba_pkg::rsp_t rsp_data
);

    `FBA_ASSERT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "response word changed while stalled")
    `FBA_ASSERT(a_one_in_flight, clk, rst_n, req_valid && req_ready |=> !req_ready, "second request taken while one is in flight")
    `FBA_ASSERT_NEVER(a_denied_zero, clk, rst_n, rsp_valid && !rsp_data.granted && (rsp_data.block_index != '0 || rsp_data.block_address != '0), "denied request shows a block")
    `FBA_ASSERT_NEVER(a_peak_bound, clk, rst_n, rsp_valid && (rsp_data.peak_in_use < rsp_data.in_use_count), "peak below in-use count")

endmodule

bind fixed_block_allocator_core fba_checker u_fba_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the fixed block allocator against its own predictor of the free list,
// the bump index, the usage counters and the block address. The tests cover
// bump limits, LIFO order, address wrap and zero stride, and pool exhaustion.
// They also run mixed traffic under several pool settings and end with a
// double free that drives the in-use count into saturation.
// ----------------------------------------------------------------------------

module testbench;

    import fba_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    req_t                req_data  = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    rsp_t                rsp_data;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [APB_AW-1:0]   paddr     = '0;
    logic [63:0]         pwdata    = '0;
    logic [63:0]         prdata;
    logic                pready;

    fixed_block_allocator_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // pool model
    logic [ADDR_W-1:0]   cfg_base   = RST_POOL_BASE;
    logic [STRIDE_W-1:0] cfg_stride = RST_BLOCK_STRIDE;
    logic [CNT_W-1:0]    cfg_limit  = RST_BLOCK_LIMIT;
    logic [IDX_W-1:0]    next_link [MAX_BLOCKS];
    bit                  link_ok   [MAX_BLOCKS];
    logic [IDX_W-1:0]    list_top   = '0;
    bit                  list_live  = 1'b0;
    logic [CNT_W-1:0]    bump_idx   = '0;
    logic [CNT_W-1:0]    held_now   = '0;
    logic [CNT_W-1:0]    held_peak  = '0;
    logic [TOTAL_W-1:0]  n_alloc    = '0;
    logic [TOTAL_W-1:0]  n_free     = '0;

    rsp_t                awaited_replies [$];
    rsp_t                last_reply;

    // stimulus bookkeeping of which blocks are handed out or on the list
    bit                  on_loan   [MAX_BLOCKS];
    bit                  listed    [MAX_BLOCKS];
    logic [IDX_W-1:0]    loaned_q  [$];

    int                  burst_left     = 0;
    int                  mismatches     = 0;
    int                  words_sent     = 0;
    int                  allocs_granted = 0;
    int                  allocs_refused = 0;
    int                  frees_taken    = 0;
    int                  settings_used  = 0;
    int                  idle_cycles    = 0;
    int                  ready_mode     = 0;
    int                  ready_left     = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        for (int k = 0; k < MAX_BLOCKS; k++)
        begin
            next_link[k] = '0;
            link_ok[k]   = 1'b0;
            on_loan[k]   = 1'b0;
            listed[k]    = 1'b0;
        end
    end

    function automatic rsp_t apply_request(input req_t w);
        rsp_t             r;
        int unsigned      cap;
        logic [IDX_W-1:0] idx;
        bit               took;
        r    = '0;
        idx  = '0;
        took = 1'b0;
        cap  = cfg_limit;
        if (cap > MAX_BLOCKS)
            cap = MAX_BLOCKS;
        if (cap > 256)
            cap = 256;
        if (w.req_type == REQ_ALLOC)
        begin
            if (list_live && int'(list_top) < MAX_BLOCKS)
            begin
                idx       = list_top;
                list_live = link_ok[idx];
                list_top  = next_link[idx];
                took      = 1'b1;
            end
            else if (bump_idx < cap)
            begin
                idx      = bump_idx[IDX_W-1:0];
                bump_idx = bump_idx + CNT_ONE;
                took     = 1'b1;
            end
            if (took)
            begin
                r.granted       = 1'b1;
                r.block_index   = idx;
                r.block_address = cfg_base + ADDR_W'(idx) * ADDR_W'(cfg_stride);
                n_alloc         = n_alloc + TOTAL_ONE;
                if (held_now != CNT_SAT)
                    held_now = held_now + CNT_ONE;
                if (held_now > held_peak)
                    held_peak = held_now;
            end
        end
        else if (int'(w.free_index) < MAX_BLOCKS)
        begin
            next_link[w.free_index] = list_top;
            link_ok[w.free_index]   = list_live;
            list_top                = w.free_index;
            list_live               = 1'b1;
            n_free                  = n_free + TOTAL_ONE;
            if (held_now != '0)
                held_now = held_now - CNT_ONE;
            r.granted = 1'b1;
        end
        r.in_use_count = held_now;
        r.peak_in_use  = held_peak;
        r.alloc_total  = n_alloc;
        r.free_total   = n_free;
        return r;
    endfunction

    function automatic req_t alloc_word();
        req_t w;
        w.req_type   = REQ_ALLOC;
        w.free_index = IDX_W'($urandom);
        return w;
    endfunction

    function automatic req_t free_word(input logic [IDX_W-1:0] idx);
        req_t w;
        w.req_type   = REQ_FREE;
        w.free_index = idx;
        return w;
    endfunction

    // one request word; the sender may idle between bursts of random length
    task automatic send_word(input req_t w);
        rsp_t r;
        int   gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        req_data  <= w;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        r = apply_request(w);
        awaited_replies.push_back(r);
        last_reply = r;
        words_sent++;
        if (w.req_type == REQ_ALLOC)
        begin
            if (r.granted)
            begin
                allocs_granted++;
                listed[r.block_index]  = 1'b0;
                on_loan[r.block_index] = 1'b1;
                loaned_q.push_back(r.block_index);
            end
            else
                allocs_refused++;
        end
        else if (r.granted)
        begin
            frees_taken++;
            listed[w.free_index] = 1'b1;
            if (on_loan[w.free_index])
            begin
                on_loan[w.free_index] = 1'b0;
                for (int k = 0; k < loaned_q.size(); k++)
                begin
                    if (loaned_q[k] == w.free_index)
                    begin
                        loaned_q.delete(k);
                        break;
                    end
                end
            end
        end
        @(negedge clk);
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [63:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (addr)
            REG_POOL_BASE:    cfg_base   = value[ADDR_W-1:0];
            REG_BLOCK_STRIDE: cfg_stride = value[STRIDE_W-1:0];
            REG_BLOCK_LIMIT:  cfg_limit  = value[CNT_W-1:0];
            default:          ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_pool(input logic [ADDR_W-1:0]   base,
                            input logic [STRIDE_W-1:0] stride,
                            input logic [CNT_W-1:0]    limit);
        wait_idle();
        write_reg(REG_POOL_BASE, base);
        write_reg(REG_BLOCK_STRIDE, 64'(stride));
        write_reg(REG_BLOCK_LIMIT, 64'(limit));
        settings_used++;
    endtask

    task automatic report_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
        mismatches++;
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endtask

    // receiver stalls on its own pattern: open, coin flip, or mostly closed
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(8, 80);
        end
        else
            ready_left--;
        case (ready_mode)
            0, 1:    rsp_ready <= 1'b1;
            2:       rsp_ready <= ($urandom_range(0, 1) == 1);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (awaited_replies.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: reply word with none expected, actual %h", $time, rsp_data);
            end
            else
            begin
                want = awaited_replies.pop_front();
                if (rsp_data.granted !== want.granted)
                    report_field("granted", want.granted, rsp_data.granted);
                if (rsp_data.block_index !== want.block_index)
                    report_field("block_index", want.block_index, rsp_data.block_index);
                if (rsp_data.block_address !== want.block_address)
                    report_field("block_address", want.block_address, rsp_data.block_address);
                if (rsp_data.in_use_count !== want.in_use_count)
                    report_field("in_use_count", want.in_use_count, rsp_data.in_use_count);
                if (rsp_data.peak_in_use !== want.peak_in_use)
                    report_field("peak_in_use", want.peak_in_use, rsp_data.peak_in_use);
                if (rsp_data.alloc_total !== want.alloc_total)
                    report_field("alloc_total", want.alloc_total, rsp_data.alloc_total);
                if (rsp_data.free_total !== want.free_total)
                    report_field("free_total", want.free_total, rsp_data.free_total);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t ns: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic test_bump_limit();
        set_pool(RST_POOL_BASE, RST_BLOCK_STRIDE, CNT_W'(1));
        send_word(alloc_word());
        send_word(alloc_word());
        send_word(free_word(IDX_W'(0)));
        send_word(free_word(IDX_W'(7)));    // in-use already zero
        send_word(alloc_word());
        send_word(alloc_word());
        send_word(alloc_word());
        set_pool(RST_POOL_BASE, RST_BLOCK_STRIDE, CNT_W'(0));
        send_word(alloc_word());
    endtask

    task automatic test_list_order();
        set_pool(RST_POOL_BASE, RST_BLOCK_STRIDE, RST_BLOCK_LIMIT);
        repeat (4) send_word(alloc_word());
        send_word(free_word(IDX_W'(255)));
        send_word(free_word(IDX_W'(2)));
        send_word(free_word(IDX_W'(4)));
        repeat (4) send_word(alloc_word());
        send_word(free_word(IDX_W'(1)));
    endtask

    task automatic test_address_range();
        set_pool('1, '1, RST_BLOCK_LIMIT);
        send_word(free_word(IDX_W'(255)));
        send_word(alloc_word());            // largest index times largest stride
        send_word(alloc_word());
        set_pool('1, '0, RST_BLOCK_LIMIT);
        send_word(alloc_word());
        set_pool(64'h8000_0000_0000_0000, STRIDE_W'(4096), RST_BLOCK_LIMIT);
        repeat (2) send_word(alloc_word());
        set_pool({$urandom, $urandom}, STRIDE_W'(1), RST_BLOCK_LIMIT);
        send_word(alloc_word());
    endtask

    task automatic test_exhaustion();
        logic [ADDR_W-1:0] base;
        int                tries;
        base  = {$urandom, $urandom};
        tries = 0;
        set_pool(base, RST_BLOCK_STRIDE, CNT_W'(300));
        do
        begin
            send_word(alloc_word());
            tries++;
        end
        while (last_reply.granted && tries < 320);
        set_pool(base, RST_BLOCK_STRIDE, '1);
        send_word(alloc_word());
    endtask

    task automatic test_mixed_traffic();
        req_t                w;
        int                  roll;
        int                  slot;
        int                  tries;
        int                  alloc_pct;
        logic [IDX_W-1:0]    cand;
        logic [STRIDE_W-1:0] stride;
        logic [CNT_W-1:0]    limit;
        repeat (5)
        begin
            case ($urandom_range(0, 4))
                0:       stride = '0;
                1:       stride = STRIDE_W'(1);
                2:       stride = STRIDE_W'(4096);
                3:       stride = '1;
                default: stride = STRIDE_W'($urandom_range(1, 4096));
            endcase
            case ($urandom_range(0, 4))
                0:       limit = '0;
                1:       limit = CNT_W'(1);
                2:       limit = CNT_W'(256);
                3:       limit = '1;
                default: limit = CNT_W'($urandom_range(0, 511));
            endcase
            set_pool({$urandom, $urandom}, stride, limit);
            alloc_pct = $urandom_range(35, 65);
            repeat (100)
            begin
                roll = $urandom_range(0, 99);
                w    = alloc_word();
                if (roll >= alloc_pct)
                begin
                    if (roll < 92 && loaned_q.size() != 0)
                    begin
                        slot = $urandom_range(0, loaned_q.size() - 1);
                        w    = free_word(loaned_q[slot]);
                    end
                    else
                    begin
                        // a block that was never handed out and is not listed
                        tries = 0;
                        do
                        begin
                            cand = IDX_W'($urandom);
                            tries++;
                        end
                        while ((on_loan[cand] || listed[cand]) && tries < 16);
                        if (!(on_loan[cand] || listed[cand]))
                            w = free_word(cand);
                    end
                end
                send_word(w);
            end
        end
    endtask

    task automatic test_counter_saturation();
        logic [IDX_W-1:0] victim;
        victim = IDX_W'($urandom);
        set_pool({$urandom, $urandom}, STRIDE_W'($urandom_range(1, 4096)), RST_BLOCK_LIMIT);
        // freeing the same block twice links it to itself, so the list never empties
        send_word(free_word(victim));
        send_word(free_word(victim));
        repeat (530) send_word(alloc_word());
        repeat (40) send_word(free_word(IDX_W'($urandom)));
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_bump_limit();
        test_list_order();
        test_address_range();
        test_exhaustion();
        test_mixed_traffic();
        test_counter_saturation();

        wait_idle();
        if (awaited_replies.size() != 0)
        begin
            mismatches++;
            $display("%0t ns: %0d reply words never arrived", $time, awaited_replies.size());
        end
        $display("Sent %0d request words: %0d allocations granted, %0d refused, %0d frees",
                 words_sent, allocs_granted, allocs_refused, frees_taken);
        $display("Pool settings applied: %0d; in-use count peaked at %0d",
                 settings_used, held_peak);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
